>>> design/pbh_pkg.sv
// ----------------------------------------------------------------------------
// pbh_pkg
// Shared types and constants for the polyline to Bezier handle streamer.
// ----------------------------------------------------------------------------
package pbh_pkg;

    // Default coordinate width (signed Q16.8 at 24 bits)
    localparam int COORD_BITS_DEF = 24;

    // Tangent gain register, unsigned Q8.16
    localparam int              GAIN_BITS  = 24;
    localparam logic [23:0]     GAIN_RESET = 24'd21845;
    localparam int              FRAC_BITS  = 16;
    localparam int              ROUND_HALF = 1 << (FRAC_BITS - 1);

    // Result kinds
    localparam logic [1:0] KIND_ANCHOR  = 2'd0;
    localparam logic [1:0] KIND_CONTROL = 2'd1;
    localparam logic [1:0] KIND_SEP     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Points seen of the open polyline
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_MANY
    } t_seen;

    // Result slots of one point, in emission order
    typedef enum logic [2:0] {
        STEP_CTRL_IN,
        STEP_ANCHOR_HELD,
        STEP_CTRL_OUT,
        STEP_CTRL_LAST,
        STEP_ANCHOR_LAST,
        STEP_SEP
    } t_step;

endpackage

>>> design/polyline_to_bezier_handles.sv
// ----------------------------------------------------------------------------
// polyline_to_bezier_handles
// Streams polyline points and emits cubic Bezier anchors and controls.
// ----------------------------------------------------------------------------
// Each accepted point is captured with its tangent differences into a work
// register, and its results leave through an output register at one result
// per cycle while the output is not stalled. A point holds the block until
// its results have left: none for the first point of a polyline, two or
// three for a later point, plus three more when it closes the polyline, one
// for a lone point. All results share a single result path (one shared pair
// of gain multipliers feeding the output register). A new point is taken in
// the cycle the previous point's last result moves to the output register,
// and the first result of a point passes through the work register and
// then the output register when the output register is free. The gain
// write port is always ready; write it only while idle.
module polyline_to_bezier_handles #(
    parameter int COORD_BITS = pbh_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // point channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_BITS-1:0]  i_point_x,
    input  logic signed [COORD_BITS-1:0]  i_point_y,
    input  logic                          i_ends_polyline,
    // handle channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_handle_x,
    output logic signed [COORD_BITS-1:0]  o_handle_y,
    output logic [1:0]                    o_handle_kind,
    output logic                          o_clipped,
    output logic                          o_last_of_run,
    // gain write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pbh_pkg::GAIN_BITS-1:0] i_cfg_data
);

    localparam int PW   = COORD_BITS + 1 + pbh_pkg::GAIN_BITS + 1;
    localparam int SW   = PW - pbh_pkg::FRAC_BITS;
    localparam int VW   = SW + 1;
    localparam int PADW = VW - COORD_BITS + 1;

    localparam logic signed [VW-1:0] C_MAX = {{PADW{1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [VW-1:0] C_MIN = {{PADW{1'b1}}, {(COORD_BITS-1){1'b0}}};

    // gain register
    logic [pbh_pkg::GAIN_BITS-1:0] r_gain;

    // polyline state
    pbh_pkg::t_seen                r_seen, n_seen;
    logic signed [COORD_BITS-1:0]  r_bx, r_by, r_hx, r_hy;

    // work register
    logic                          r_busy, n_busy;
    logic                          r_err;
    pbh_pkg::t_step                r_pos, r_end;
    logic signed [COORD_BITS-1:0]  r_px, r_py, r_ax, r_ay;
    logic signed [COORD_BITS:0]    r_d1x, r_d1y, r_d2x, r_d2y;

    // output register
    logic                          r_out_valid;
    logic signed [COORD_BITS-1:0]  r_ox, r_oy;
    logic [1:0]                    r_okind;
    logic                          r_oclip, r_olast;

    logic                          w_accept, w_emit, w_last, w_done, w_load_work;
    logic                          w_err;
    pbh_pkg::t_step                w_start, w_end;
    logic signed [COORD_BITS:0]    w_px_e, w_py_e, w_d1x, w_d1y, w_d2x, w_d2y;

    // handshake
    assign w_emit      = r_busy && (!r_out_valid || i_out_ready);
    assign w_last      = r_err || (r_pos == r_end);
    assign w_done      = w_emit && w_last;
    assign o_in_ready  = !r_busy || w_done;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // gain write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= pbh_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // next polyline state
    always_comb begin
        n_seen = r_seen;
        if (w_accept) begin
            if (i_ends_polyline) begin
                n_seen = pbh_pkg::SEEN_NONE;
            end else if (r_seen == pbh_pkg::SEEN_NONE) begin
                n_seen = pbh_pkg::SEEN_ONE;
            end else begin
                n_seen = pbh_pkg::SEEN_MANY;
            end
        end
    end

    // decode the result slots and tangent differences of the incoming point
    assign w_px_e = {i_point_x[COORD_BITS-1], i_point_x};
    assign w_py_e = {i_point_y[COORD_BITS-1], i_point_y};

    always_comb begin
        w_err       = 1'b0;
        w_load_work = 1'b1;
        w_start     = pbh_pkg::STEP_ANCHOR_HELD;
        w_end       = i_ends_polyline ? pbh_pkg::STEP_SEP : pbh_pkg::STEP_CTRL_OUT;
        w_d2x       = w_px_e - {r_hx[COORD_BITS-1], r_hx};
        w_d2y       = w_py_e - {r_hy[COORD_BITS-1], r_hy};
        w_d1x       = w_d2x;
        w_d1y       = w_d2y;
        unique case (r_seen)
            pbh_pkg::SEEN_NONE: begin
                w_err       = 1'b1;
                w_load_work = i_ends_polyline;
            end
            pbh_pkg::SEEN_ONE: begin
                w_start = pbh_pkg::STEP_ANCHOR_HELD;
            end
            pbh_pkg::SEEN_MANY: begin
                w_start = pbh_pkg::STEP_CTRL_IN;
                w_d1x   = w_px_e - {r_bx[COORD_BITS-1], r_bx};
                w_d1y   = w_py_e - {r_by[COORD_BITS-1], r_by};
            end
            default: begin
                w_load_work = 1'b0;
            end
        endcase
    end

    // polyline state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= pbh_pkg::SEEN_NONE;
            r_bx   <= '0;
            r_by   <= '0;
            r_hx   <= '0;
            r_hy   <= '0;
        end else begin
            r_seen <= n_seen;
            if (w_accept && !i_ends_polyline) begin
                r_bx <= r_hx;
                r_by <= r_hy;
                r_hx <= i_point_x;
                r_hy <= i_point_y;
            end
        end
    end

    // work register occupancy
    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = w_load_work;
        end else if (w_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= pbh_pkg::STEP_CTRL_IN;
        end else begin
            r_busy <= n_busy;
            if (w_accept) begin
                r_pos <= w_start;
            end else if (w_emit) begin
                r_pos <= pbh_pkg::t_step'(r_pos + 3'd1);
            end
        end
    end

    // capture point, held anchor and differences
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err <= w_err;
            r_end <= w_end;
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_ax  <= r_hx;
            r_ay  <= r_hy;
            r_d1x <= w_d1x;
            r_d1y <= w_d1y;
            r_d2x <= w_d2x;
            r_d2y <= w_d2y;
        end
    end

    // select the anchor, difference and direction of the current control
    logic signed [COORD_BITS-1:0] w_anc [2];
    logic signed [COORD_BITS:0]   w_dif [2];
    logic                         w_minus;
    logic signed [PW-1:0]         w_prod [2];
    logic signed [SW-1:0]         w_scl [2];
    logic signed [VW-1:0]         w_sum [2];
    logic signed [COORD_BITS-1:0] w_ctl [2];
    logic [1:0]                   w_clip;

    always_comb begin
        w_anc[0] = r_ax;
        w_anc[1] = r_ay;
        w_dif[0] = r_d1x;
        w_dif[1] = r_d1y;
        w_minus  = 1'b1;
        if (r_pos == pbh_pkg::STEP_CTRL_OUT) begin
            w_minus = 1'b0;
        end else if (r_pos == pbh_pkg::STEP_CTRL_LAST) begin
            w_anc[0] = r_px;
            w_anc[1] = r_py;
            w_dif[0] = r_d2x;
            w_dif[1] = r_d2y;
        end
    end

    // scale by gain, round to nearest, offset the anchor and saturate
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_prod[i] = w_dif[i] * $signed({1'b0, r_gain});
            w_scl[i]  = SW'((w_prod[i] + PW'(pbh_pkg::ROUND_HALF)) >>> pbh_pkg::FRAC_BITS);
            w_sum[i]  = w_minus ? (VW'(w_anc[i]) - VW'(w_scl[i]))
                                : (VW'(w_anc[i]) + VW'(w_scl[i]));
            w_clip[i] = 1'b0;
            if (w_sum[i] > C_MAX) begin
                w_ctl[i]  = C_MAX[COORD_BITS-1:0];
                w_clip[i] = 1'b1;
            end else if (w_sum[i] < C_MIN) begin
                w_ctl[i]  = C_MIN[COORD_BITS-1:0];
                w_clip[i] = 1'b1;
            end else begin
                w_ctl[i] = w_sum[i][COORD_BITS-1:0];
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_olast <= w_last;
            r_oclip <= 1'b0;
            if (r_err) begin
                r_ox    <= r_px;
                r_oy    <= r_py;
                r_okind <= pbh_pkg::KIND_ERROR;
            end else begin
                unique case (r_pos)
                    pbh_pkg::STEP_CTRL_IN,
                    pbh_pkg::STEP_CTRL_OUT,
                    pbh_pkg::STEP_CTRL_LAST: begin
                        r_ox    <= w_ctl[0];
                        r_oy    <= w_ctl[1];
                        r_okind <= pbh_pkg::KIND_CONTROL;
                        r_oclip <= |w_clip;
                    end
                    pbh_pkg::STEP_ANCHOR_HELD: begin
                        r_ox    <= r_ax;
                        r_oy    <= r_ay;
                        r_okind <= pbh_pkg::KIND_ANCHOR;
                    end
                    pbh_pkg::STEP_ANCHOR_LAST: begin
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_okind <= pbh_pkg::KIND_ANCHOR;
                    end
                    default: begin
                        r_ox    <= '0;
                        r_oy    <= '0;
                        r_okind <= pbh_pkg::KIND_SEP;
                    end
                endcase
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_handle_x    = r_ox;
    assign o_handle_y    = r_oy;
    assign o_handle_kind = r_okind;
    assign o_clipped     = r_oclip;
    assign o_last_of_run = r_olast;

endmodule

>>> design/pbh_checker.sv
// ----------------------------------------------------------------------------
// pbh_checker
// Port-level checks for the polyline to Bezier handle streamer.
// ----------------------------------------------------------------------------
module pbh_checker #(
    parameter int COORD_BITS = pbh_pkg::COORD_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [COORD_BITS-1:0]  i_point_x,
    input logic signed [COORD_BITS-1:0]  i_point_y,
    input logic                          i_ends_polyline,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_BITS-1:0]  o_handle_x,
    input logic signed [COORD_BITS-1:0]  o_handle_y,
    input logic [1:0]                    o_handle_kind,
    input logic                          o_clipped,
    input logic                          o_last_of_run,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [pbh_pkg::GAIN_BITS-1:0] i_cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_handle_x)
            && $stable(o_handle_y) && $stable(o_handle_kind) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // separator closes the run with a zero payload
    a_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_handle_kind == pbh_pkg::KIND_SEP |->
            o_last_of_run && !o_clipped && o_handle_x == '0 && o_handle_y == '0)
        else $error("bad separator");

    // a lone point gives one unclipped result
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_handle_kind == pbh_pkg::KIND_ERROR |-> o_last_of_run && !o_clipped)
        else $error("bad single point result");

    // anchors never saturate
    a_anchor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_handle_kind == pbh_pkg::KIND_ANCHOR |-> !o_clipped)
        else $error("clipped anchor");

endmodule

bind polyline_to_bezier_handles pbh_checker #(.COORD_BITS(COORD_BITS)) u_pbh_checker (.*);
